// ----- sv/hsvrgb_pkg.sv -----
// Package: pixel types, stage records and fixed-point helpers for the HSV to RGB converter.
package hsvrgb_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned CompW    = FracBits + 1;
  localparam int unsigned ProdW    = 2 * CompW;
  localparam int unsigned SectW    = FracBits + 3;
  localparam logic [CompW-1:0] OneFx = CompW'(1) << FracBits;

  typedef enum logic [2:0] {
    SectRed     = 3'd0,
    SectYellow  = 3'd1,
    SectGreen   = 3'd2,
    SectCyan    = 3'd3,
    SectBlue    = 3'd4,
    SectMagenta = 3'd5
  } sector_e;

  typedef struct packed {
    logic [FracBits-1:0] hue;
    logic [CompW-1:0]    saturation;
    logic [CompW-1:0]    brightness;
  } hsv_t;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                valid;
    logic [2:0]          sel;
    logic [FracBits-1:0] f;
    logic [CompW-1:0]    s;
    logic [CompW-1:0]    v;
    logic [CompW-1:0]    oms;
  } prep_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       sel;
    logic [CompW-1:0] v;
    logic [CompW-1:0] p;
    logic [CompW-1:0] sf;
    logic [CompW-1:0] s1f;
  } prod_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       sel;
    logic [CompW-1:0] v;
    logic [CompW-1:0] p;
    logic [CompW-1:0] q;
    logic [CompW-1:0] t;
  } term_t;

  function automatic logic [CompW-1:0] fx_mul(input logic [CompW-1:0] a,
                                              input logic [CompW-1:0] b);
    logic [ProdW-1:0] prod;
    prod = ProdW'(a) * ProdW'(b);
    return prod[FracBits +: CompW];
  endfunction

endpackage

// ----- sv/hsvrgb_prep.sv -----
// Input stage: clamp saturation and brightness, split the scaled hue into sector and fraction.
module hsvrgb_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hsvrgb_pkg::hsv_t    pixel_i,
  output hsvrgb_pkg::prep_t   prep_o
);

  logic [hsvrgb_pkg::SectW-1:0]    sect_w;
  logic [hsvrgb_pkg::CompW-1:0]    s_clamp;
  logic [hsvrgb_pkg::CompW-1:0]    v_clamp;
  logic                            valid_q;
  logic [2:0]                      sel_q;
  logic [hsvrgb_pkg::FracBits-1:0] f_q;
  logic [hsvrgb_pkg::CompW-1:0]    s_q;
  logic [hsvrgb_pkg::CompW-1:0]    v_q;
  logic [hsvrgb_pkg::CompW-1:0]    oms_q;

  assign sect_w  = {1'b0, pixel_i.hue, 2'b00} + {2'b00, pixel_i.hue, 1'b0};
  assign s_clamp = (pixel_i.saturation > hsvrgb_pkg::OneFx) ? hsvrgb_pkg::OneFx
                                                            : pixel_i.saturation;
  assign v_clamp = (pixel_i.brightness > hsvrgb_pkg::OneFx) ? hsvrgb_pkg::OneFx
                                                            : pixel_i.brightness;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sect_w[hsvrgb_pkg::SectW-1 -: 3];
    f_q   <= sect_w[hsvrgb_pkg::FracBits-1:0];
    s_q   <= s_clamp;
    v_q   <= v_clamp;
    oms_q <= hsvrgb_pkg::OneFx - s_clamp;
  end

  assign prep_o = '{valid: valid_q, sel: sel_q, f: f_q, s: s_q, v: v_q, oms: oms_q};

endmodule

// ----- sv/hsvrgb_mul.sv -----
// Multiplier stages: form s*f, s*(1-f) and p, then q and t from the complements.
module hsvrgb_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsvrgb_pkg::prep_t  prep_i,
  output hsvrgb_pkg::term_t  term_o
);

  hsvrgb_pkg::prod_t            prod;
  logic                         prod_valid_q;
  logic [2:0]                   prod_sel_q;
  logic [hsvrgb_pkg::CompW-1:0] prod_v_q;
  logic [hsvrgb_pkg::CompW-1:0] prod_p_q;
  logic [hsvrgb_pkg::CompW-1:0] prod_sf_q;
  logic [hsvrgb_pkg::CompW-1:0] prod_s1f_q;
  logic [hsvrgb_pkg::CompW-1:0] f_ext;
  logic                         term_valid_q;
  logic [2:0]                   term_sel_q;
  logic [hsvrgb_pkg::CompW-1:0] term_v_q;
  logic [hsvrgb_pkg::CompW-1:0] term_p_q;
  logic [hsvrgb_pkg::CompW-1:0] term_q_q;
  logic [hsvrgb_pkg::CompW-1:0] term_t_q;

  assign f_ext = {1'b0, prep_i.f};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      term_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= prep_i.valid;
      term_valid_q <= prod.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_sel_q <= prep_i.sel;
    prod_v_q   <= prep_i.v;
    prod_p_q   <= hsvrgb_pkg::fx_mul(prep_i.v, prep_i.oms);
    prod_sf_q  <= hsvrgb_pkg::fx_mul(prep_i.s, f_ext);
    prod_s1f_q <= hsvrgb_pkg::fx_mul(prep_i.s, hsvrgb_pkg::OneFx - f_ext);
  end

  assign prod = '{valid: prod_valid_q, sel: prod_sel_q, v: prod_v_q, p: prod_p_q,
                  sf: prod_sf_q, s1f: prod_s1f_q};

  always_ff @(posedge clk_i) begin
    term_sel_q <= prod.sel;
    term_v_q   <= prod.v;
    term_p_q   <= prod.p;
    term_q_q   <= hsvrgb_pkg::fx_mul(prod.v, hsvrgb_pkg::OneFx - prod.sf);
    term_t_q   <= hsvrgb_pkg::fx_mul(prod.v, hsvrgb_pkg::OneFx - prod.s1f);
  end

  assign term_o = '{valid: term_valid_q, sel: term_sel_q, v: term_v_q, p: term_p_q,
                    q: term_q_q, t: term_t_q};

endmodule

// ----- sv/hsvrgb_route.sv -----
// Output stage: route v, p, q and t to red, green and blue by sector.
module hsvrgb_route (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsvrgb_pkg::term_t  term_i,
  output logic               valid_o,
  output hsvrgb_pkg::rgb_t   result_o
);

  hsvrgb_pkg::rgb_t rgb_d;
  hsvrgb_pkg::rgb_t rgb_q;
  logic             valid_q;

  always_comb begin
    case (hsvrgb_pkg::sector_e'(term_i.sel))
      hsvrgb_pkg::SectRed:    rgb_d = '{red: term_i.v, green: term_i.t, blue: term_i.p};
      hsvrgb_pkg::SectYellow: rgb_d = '{red: term_i.q, green: term_i.v, blue: term_i.p};
      hsvrgb_pkg::SectGreen:  rgb_d = '{red: term_i.p, green: term_i.v, blue: term_i.t};
      hsvrgb_pkg::SectCyan:   rgb_d = '{red: term_i.p, green: term_i.q, blue: term_i.v};
      hsvrgb_pkg::SectBlue:   rgb_d = '{red: term_i.t, green: term_i.p, blue: term_i.v};
      default:                rgb_d = '{red: term_i.v, green: term_i.p, blue: term_i.q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= term_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign valid_o  = valid_q;
  assign result_o = rgb_q;

endmodule

// ----- sv/hsv_to_rgb_converter_core.sv -----
// Top level: four-stage pipelined HSV to RGB converter, six-sector method.
// A pixel is taken at every clock edge where start_i is high; busy_o is always low, so a new
// transaction may follow in every cycle. Each result appears on result_o for exactly one cycle,
// marked by valid_o, once its pixel has passed the four register stages; results leave in
// order and the receiver cannot stall. The stages are clamp and sector split, the three first
// products, the q and t products, and the sector routing.
module hsv_to_rgb_converter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hsvrgb_pkg::hsv_t  pixel_i,
  output logic              busy_o,
  output logic              valid_o,
  output hsvrgb_pkg::rgb_t  result_o
);

  hsvrgb_pkg::prep_t prep;
  hsvrgb_pkg::term_t term;

  assign busy_o = 1'b0;

  hsvrgb_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .pixel_i (pixel_i),
    .prep_o  (prep)
  );

  hsvrgb_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .prep_i (prep),
    .term_o (term)
  );

  hsvrgb_route u_route (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .term_i   (term),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  a_result_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 4))
    else $error("result without a transaction four cycles earlier");

  a_grey_on_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(pixel_i.saturation, 4) == '0) |->
      (result_o.red == result_o.green && result_o.green == result_o.blue))
    else $error("zero saturation did not give grey");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.red <= hsvrgb_pkg::OneFx && result_o.green <= hsvrgb_pkg::OneFx
                 && result_o.blue <= hsvrgb_pkg::OneFx))
    else $error("colour component above one");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench: drives HSV pixels into the converter and checks every RGB result against a predictor.
module tb;

  localparam int unsigned BurstCount  = 60;
  localparam int unsigned StreamCount = 470;
  localparam int unsigned DrainEvery  = 120;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam logic [hsvrgb_pkg::CompW-1:0] CompMax = '1;
  localparam logic [hsvrgb_pkg::CompW-1:0] HalfFx  = hsvrgb_pkg::OneFx >> 1;
  localparam logic [hsvrgb_pkg::SectW-1:0] SectorCount =
    {{(hsvrgb_pkg::SectW-3){1'b0}}, 3'd6};

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic valid_o;
  hsvrgb_pkg::hsv_t pixel_i;
  hsvrgb_pkg::rgb_t result_o;

  hsvrgb_pkg::rgb_t expected_rgb[$];
  int unsigned mismatch_count  = 0;
  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned grey_pixels     = 0;
  int unsigned clamped_pixels  = 0;
  int unsigned cycle_count     = 0;

  hsv_to_rgb_converter_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .pixel_i  (pixel_i),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [hsvrgb_pkg::CompW-1:0] scaled_product(
      input logic [hsvrgb_pkg::CompW-1:0] a,
      input logic [hsvrgb_pkg::CompW-1:0] b);
    logic [hsvrgb_pkg::ProdW-1:0] wide;
    wide = {{hsvrgb_pkg::CompW{1'b0}}, a} * {{hsvrgb_pkg::CompW{1'b0}}, b};
    return wide[hsvrgb_pkg::FracBits +: hsvrgb_pkg::CompW];
  endfunction

  function automatic logic [hsvrgb_pkg::CompW-1:0] clamp_unit(
      input logic [hsvrgb_pkg::CompW-1:0] x);
    return (x > hsvrgb_pkg::OneFx) ? hsvrgb_pkg::OneFx : x;
  endfunction

  function automatic hsvrgb_pkg::rgb_t predict_rgb(input hsvrgb_pkg::hsv_t px);
    logic [hsvrgb_pkg::CompW-1:0]    s;
    logic [hsvrgb_pkg::CompW-1:0]    v;
    logic [hsvrgb_pkg::CompW-1:0]    p;
    logic [hsvrgb_pkg::CompW-1:0]    q;
    logic [hsvrgb_pkg::CompW-1:0]    t;
    logic [hsvrgb_pkg::FracBits-1:0] f;
    logic [hsvrgb_pkg::SectW-1:0]    scaled;
    hsvrgb_pkg::sector_e             sector;
    hsvrgb_pkg::rgb_t                c;
    s      = clamp_unit(px.saturation);
    v      = clamp_unit(px.brightness);
    scaled = {{(hsvrgb_pkg::SectW-hsvrgb_pkg::FracBits){1'b0}}, px.hue} * SectorCount;
    sector = hsvrgb_pkg::sector_e'(scaled[hsvrgb_pkg::SectW-1 -: 3]);
    f      = scaled[hsvrgb_pkg::FracBits-1:0];
    p      = scaled_product(v, hsvrgb_pkg::OneFx - s);
    q      = scaled_product(v, hsvrgb_pkg::OneFx - scaled_product(s, {1'b0, f}));
    t      = scaled_product(v, hsvrgb_pkg::OneFx
                               - scaled_product(s, hsvrgb_pkg::OneFx - {1'b0, f}));
    if (s == '0) begin
      c = '{red: v, green: v, blue: v};
    end else begin
      case (sector)
        hsvrgb_pkg::SectRed: begin
          c = '{red: v, green: t, blue: p};
        end
        hsvrgb_pkg::SectYellow: begin
          c = '{red: q, green: v, blue: p};
        end
        hsvrgb_pkg::SectGreen: begin
          c = '{red: p, green: v, blue: t};
        end
        hsvrgb_pkg::SectCyan: begin
          c = '{red: p, green: q, blue: v};
        end
        hsvrgb_pkg::SectBlue: begin
          c = '{red: t, green: p, blue: v};
        end
        default: begin
          c = '{red: v, green: p, blue: q};
        end
      endcase
    end
    return c;
  endfunction

  function automatic hsvrgb_pkg::hsv_t random_pixel();
    hsvrgb_pkg::hsv_t px;
    int unsigned      mode;
    logic [31:0]      draw;
    mode   = $urandom_range(0, 9);
    draw   = $urandom_range(0, 16'hFFFF);
    px.hue = draw[hsvrgb_pkg::FracBits-1:0];
    if (mode <= 5) begin
      draw          = $urandom_range(0, hsvrgb_pkg::OneFx);
      px.saturation = draw[hsvrgb_pkg::CompW-1:0];
      draw          = $urandom_range(0, hsvrgb_pkg::OneFx);
      px.brightness = draw[hsvrgb_pkg::CompW-1:0];
    end else if (mode <= 7) begin
      draw          = $urandom_range(0, CompMax);
      px.saturation = draw[hsvrgb_pkg::CompW-1:0];
      draw          = $urandom_range(0, CompMax);
      px.brightness = draw[hsvrgb_pkg::CompW-1:0];
    end else if (mode == 8) begin
      px.saturation = '0;
      draw          = $urandom_range(0, CompMax);
      px.brightness = draw[hsvrgb_pkg::CompW-1:0];
    end else begin
      px.saturation = hsvrgb_pkg::OneFx;
      px.brightness = hsvrgb_pkg::OneFx;
    end
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Hold start high until the transaction is taken, then queue its colour.
  task automatic send_pixel(input hsvrgb_pkg::hsv_t px);
    @(negedge clk_i);
    start_i <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy_o);
    expected_rgb.push_back(predict_rgb(px));
    pixels_sent++;
    if (px.saturation == '0) begin
      grey_pixels++;
    end
    if (px.saturation > hsvrgb_pkg::OneFx || px.brightness > hsvrgb_pkg::OneFx) begin
      clamped_pixels++;
    end
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      pixel_i <= random_pixel();
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    hsvrgb_pkg::rgb_t want;
    if (rst_ni && valid_o) begin
      if (expected_rgb.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction pending", result_o));
      end else begin
        want = expected_rgb.pop_front();
        results_checked++;
        if (result_o.red !== want.red) begin
          report_mismatch($sformatf("red %h, want %h", result_o.red, want.red));
        end
        if (result_o.green !== want.green) begin
          report_mismatch($sformatf("green %h, want %h", result_o.green, want.green));
        end
        if (result_o.blue !== want.blue) begin
          report_mismatch($sformatf("blue %h, want %h", result_o.blue, want.blue));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_grey_and_extremes();
    send_pixel('{16'h0000, '0, '0});
    send_pixel('{16'h4321, '0, hsvrgb_pkg::OneFx});
    send_pixel('{16'hFFFF, '0, 17'h0ABCD});
    send_pixel('{16'h0000, hsvrgb_pkg::OneFx, hsvrgb_pkg::OneFx});
    send_pixel('{16'hFFFF, hsvrgb_pkg::OneFx, hsvrgb_pkg::OneFx});
    send_pixel('{16'h2000, CompMax, CompMax});
    send_pixel('{16'h9000, 17'h10001, 17'h0C000});
    send_pixel('{16'h6000, HalfFx, 17'h18000});
    send_pixel('{16'h1234, 17'h00001, hsvrgb_pkg::OneFx});
    send_pixel('{16'hF000, hsvrgb_pkg::OneFx, 17'h00001});
  endtask

  // Straddle the sector boundaries of the hue scaled by six; the one at half scale is hit exactly.
  task automatic test_sector_boundaries();
    send_pixel('{16'd10922, hsvrgb_pkg::OneFx, hsvrgb_pkg::OneFx});
    send_pixel('{16'd10923, hsvrgb_pkg::OneFx, 17'h0F00F});
    send_pixel('{16'd21845, HalfFx, hsvrgb_pkg::OneFx});
    send_pixel('{16'd21846, hsvrgb_pkg::OneFx, 17'h08000});
    send_pixel('{16'd32768, 17'h0C000, hsvrgb_pkg::OneFx});
    send_pixel('{16'd43690, hsvrgb_pkg::OneFx, 17'h0FFFF});
    send_pixel('{16'd43691, 17'h0FFFF, hsvrgb_pkg::OneFx});
    send_pixel('{16'd54613, hsvrgb_pkg::OneFx, 17'h04000});
    send_pixel('{16'd54614, HalfFx, 17'h0FFFF});
  endtask

  task automatic test_burst();
    repeat (BurstCount) send_pixel(random_pixel());
  endtask

  task automatic test_random_stream();
    int unsigned roll;
    for (int unsigned n = 1; n <= StreamCount; n++) begin
      send_pixel(random_pixel());
      roll = $urandom_range(0, 99);
      if (roll >= 95) begin
        idle_for($urandom_range(8, 40));
      end else if (roll >= 65) begin
        idle_for($urandom_range(1, 3));
      end
      if (n % DrainEvery == 0) begin
        drain_pipeline();
      end
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    pixel_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_grey_and_extremes();
    test_sector_boundaries();
    test_burst();
    test_random_stream();

    drain_pipeline();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_rgb.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_rgb.size()));
    end

    $display("sent %0d pixels, checked %0d colours, %0d mismatches", pixels_sent,
             results_checked, mismatch_count);
    $display("included %0d grey pixels and %0d with saturation or value over one",
             grey_pixels, clamped_pixels);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hsvrgb_pkg.sv
sv/hsvrgb_prep.sv
sv/hsvrgb_mul.sv
sv/hsvrgb_route.sv
sv/hsv_to_rgb_converter_core.sv
tb/tb.sv
